[src/tpqs_pkg.sv]
// ----------------------------------------------------------------------------
// tpqs_pkg
// Shared types and constants for the three-level priority queue scheduler.
// ----------------------------------------------------------------------------
package tpqs_pkg;

   localparam int QueueDepthDefault  = 16;
   localparam int HandleWidthDefault = 16;

   localparam int ModeWidth   = 2;
   localparam int LevelWidth  = 2;
   localparam int StatusWidth = 2;
   localparam int BurstWidth  = 8;
   localparam int NumLevels   = 3;

   localparam logic [BurstWidth-1:0] BurstLimitReset = 8'd4;

   typedef enum logic [ModeWidth-1:0] {
      OP_ENQ  = 2'd0,
      OP_DEQ  = 2'd1,
      OP_STOP = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [LevelWidth-1:0] {
      LVL_LOW    = 2'd0,
      LVL_NORMAL = 2'd1,
      LVL_HIGH   = 2'd2
   } level_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_STOPPED = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      op_type    op;
      level_type level;
   } cmd_ctl_type;

endpackage

[src/tpqs_front.sv]
// ----------------------------------------------------------------------------
// tpqs_front
// Request intake: unpacks a request word and classifies it into a command.
// ----------------------------------------------------------------------------
module tpqs_front
   import tpqs_pkg::*;
#(
   parameter int HANDLE_WIDTH = HandleWidthDefault,
   parameter int DATA_WIDTH   = 24
) (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ModeWidth-1:0]    req_tuser,
   input  logic [DATA_WIDTH-1:0]   req_tdata,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output cmd_ctl_type             cmd_ctl,
   output logic [HANDLE_WIDTH-1:0] cmd_handle
);

   logic [LevelWidth-1:0] prio_raw;

   assign prio_raw   = req_tdata[LevelWidth-1:0];
   assign cmd_handle = req_tdata[LevelWidth +: HANDLE_WIDTH];
   assign cmd_valid  = req_tvalid;
   assign req_tready = cmd_ready;

   always_comb begin
      cmd_ctl.op = op_type'(req_tuser);
      unique case (prio_raw)
         2'd0:    cmd_ctl.level = LVL_LOW;
         2'd1:    cmd_ctl.level = LVL_NORMAL;
         default: cmd_ctl.level = LVL_HIGH;  // priority three counts as high
      endcase
   end

endmodule

[src/tpqs_cmd_queue.sv]
// ----------------------------------------------------------------------------
// tpqs_cmd_queue
// Two-entry command queue between the intake and the queue engine.
// ----------------------------------------------------------------------------
module tpqs_cmd_queue
   import tpqs_pkg::*;
#(
   parameter int HANDLE_WIDTH = HandleWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmd_ctl_type             in_ctl,
   input  logic [HANDLE_WIDTH-1:0] in_handle,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cmd_ctl_type             out_ctl,
   output logic [HANDLE_WIDTH-1:0] out_handle
);

   cmd_ctl_type             ctl_ff [2];
   logic [HANDLE_WIDTH-1:0] hnd_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    push, pop;

   assign in_ready   = (count_ff != 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign push       = in_valid && in_ready;
   assign pop        = out_valid && out_ready;
   assign out_ctl    = ctl_ff[rd_ptr_ff];
   assign out_handle = hnd_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctl_ff[wr_ptr_ff] <= in_ctl;
         hnd_ff[wr_ptr_ff] <= in_handle;
      end
   end

endmodule

[src/tpqs_engine.sv]
// ----------------------------------------------------------------------------
// tpqs_engine
// Queue engine: three handle FIFOs, burst-limited strict priority grant,
// stop flag and the registered response stage.
// ----------------------------------------------------------------------------
module tpqs_engine
   import tpqs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QueueDepthDefault,
   parameter int HANDLE_WIDTH = HandleWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [BurstWidth-1:0]   csr_wr_data,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  cmd_ctl_type             cmd_ctl,
   input  logic [HANDLE_WIDTH-1:0] cmd_handle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output status_type              rsp_status,
   output logic [HANDLE_WIDTH-1:0] rsp_handle,
   output level_type               rsp_level
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   logic [PtrWidth-1:0]     head_ff  [NumLevels];
   logic [PtrWidth-1:0]     tail_ff  [NumLevels];
   logic [CntWidth-1:0]     count_ff [NumLevels];
   logic [HANDLE_WIDTH-1:0] rd_ff    [NumLevels];

   logic [NumLevels-1:0]  nonempty, full, push, pop;
   logic                  load;

   logic [BurstWidth-1:0] limit_ff, limit_in;
   logic [BurstWidth-1:0] run_ff, run_in;
   logic                  stopped_ff, stopped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic                  grant_ff, grant_in;
   level_type             level_ff, level_in;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign load      = cmd_valid && cmd_ready;

   for (genvar l = 0; l < NumLevels; l++) begin : g_level
      logic [HANDLE_WIDTH-1:0] mem [QUEUE_DEPTH];
      logic [PtrWidth-1:0]     head_in, tail_in;
      logic [CntWidth-1:0]     count_in;

      assign nonempty[l] = (count_ff[l] != '0);
      assign full[l]     = (count_ff[l] == CntWidth'(QUEUE_DEPTH));

      always_comb begin
         head_in  = head_ff[l];
         tail_in  = tail_ff[l];
         count_in = count_ff[l];
         if (push[l]) begin
            tail_in  = (tail_ff[l] == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : tail_ff[l] + 1'b1;
            count_in = count_ff[l] + 1'b1;
         end
         if (pop[l]) begin
            head_in  = (head_ff[l] == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : head_ff[l] + 1'b1;
            count_in = count_ff[l] - 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            head_ff[l]  <= '0;
            tail_ff[l]  <= '0;
            count_ff[l] <= '0;
         end else begin
            head_ff[l]  <= head_in;
            tail_ff[l]  <= tail_in;
            count_ff[l] <= count_in;
         end
      end

      always_ff @(posedge clock) begin
         if (push[l]) begin
            mem[tail_ff[l]] <= cmd_handle;
         end
         if (pop[l]) begin
            rd_ff[l] <= mem[head_ff[l]];
         end
      end
   end

   always_comb begin
      push       = '0;
      pop        = '0;
      status_in  = ST_OK;
      grant_in   = 1'b0;
      level_in   = LVL_LOW;
      run_in     = run_ff;
      stopped_in = stopped_ff;
      limit_in   = csr_wr_en ? csr_wr_data : limit_ff;
      if (load) begin
         unique case (cmd_ctl.op)
            OP_ENQ: begin
               priority if (stopped_ff) begin
                  status_in = ST_STOPPED;
               end else if (full[cmd_ctl.level]) begin
                  status_in = ST_FULL;
               end else begin
                  push[cmd_ctl.level] = 1'b1;
               end
            end
            OP_DEQ: begin
               priority if (stopped_ff) begin
                  status_in = ST_STOPPED;
               end else if (nonempty[LVL_HIGH] && (run_ff < limit_ff)) begin
                  pop[LVL_HIGH] = 1'b1;
                  grant_in      = 1'b1;
                  level_in      = LVL_HIGH;
                  run_in        = run_ff + 1'b1;
               end else if (nonempty[LVL_NORMAL]) begin
                  pop[LVL_NORMAL] = 1'b1;
                  grant_in        = 1'b1;
                  level_in        = LVL_NORMAL;
                  run_in          = '0;
               end else if (nonempty[LVL_LOW]) begin
                  pop[LVL_LOW] = 1'b1;
                  grant_in     = 1'b1;
                  level_in     = LVL_LOW;
                  run_in       = '0;
               end else if (nonempty[LVL_HIGH]) begin
                  // only high work left past the limit: serve it, keep the run
                  pop[LVL_HIGH] = 1'b1;
                  grant_in      = 1'b1;
                  level_in      = LVL_HIGH;
               end else begin
                  status_in = ST_EMPTY;
               end
            end
            OP_STOP: stopped_in = 1'b1;
            OP_NONE: ;
         endcase
      end
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= BurstLimitReset;
         run_ff       <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         run_ff       <= run_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         grant_ff  <= grant_in;
         level_ff  <= level_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_level  = level_ff;

   always_comb begin
      rsp_handle = '0;
      if (grant_ff) begin
         unique case (level_ff)
            LVL_LOW:    rsp_handle = rd_ff[LVL_LOW];
            LVL_NORMAL: rsp_handle = rd_ff[LVL_NORMAL];
            default:    rsp_handle = rd_ff[LVL_HIGH];
         endcase
      end
   end

endmodule

[src/three_level_priority_queue_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// three_level_priority_queue_scheduler_unit
// A request passes through the command queue and then the registered response stage.
// Throughput: 1 word per cycle while the response side accepts; the two-entry command queue and the response
// register let intake and engine stall independently.
// Reset: synchronous; all queues empty, run count 0, running, burst limit 4.
// ----------------------------------------------------------------------------
module three_level_priority_queue_scheduler_unit
   import tpqs_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QueueDepthDefault,
   parameter int HANDLE_WIDTH = HandleWidthDefault
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_wr_en,
   input  logic [BurstWidth-1:0]                        csr_wr_data,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   input  logic [ModeWidth-1:0]                         req_tuser,  // mode
   input  logic [((LevelWidth+HANDLE_WIDTH+7)/8)*8-1:0] req_tdata,  // priority_req, job_handle
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   output logic [StatusWidth-1:0]                       rsp_tuser,  // status
   output logic [((HANDLE_WIDTH+LevelWidth+7)/8)*8-1:0] rsp_tdata   // granted_handle, granted_priority
);

   localparam int ReqDataWidth = ((LevelWidth + HANDLE_WIDTH + 7) / 8) * 8;
   localparam int RspDataWidth = ((HANDLE_WIDTH + LevelWidth + 7) / 8) * 8;

   logic                    f_valid, f_ready;
   cmd_ctl_type             f_ctl;
   logic [HANDLE_WIDTH-1:0] f_handle;
   logic                    q_valid, q_ready;
   cmd_ctl_type             q_ctl;
   logic [HANDLE_WIDTH-1:0] q_handle;
   status_type              e_status;
   logic [HANDLE_WIDTH-1:0] e_handle;
   level_type               e_level;

   tpqs_front #(
      .HANDLE_WIDTH (HANDLE_WIDTH),
      .DATA_WIDTH   (ReqDataWidth)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd_ctl    (f_ctl),
      .cmd_handle (f_handle)
   );

   tpqs_cmd_queue #(
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_ready   (f_ready),
      .in_ctl     (f_ctl),
      .in_handle  (f_handle),
      .out_valid  (q_valid),
      .out_ready  (q_ready),
      .out_ctl    (q_ctl),
      .out_handle (q_handle)
   );

   tpqs_engine #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .HANDLE_WIDTH (HANDLE_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_valid   (q_valid),
      .cmd_ready   (q_ready),
      .cmd_ctl     (q_ctl),
      .cmd_handle  (q_handle),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (e_status),
      .rsp_handle  (e_handle),
      .rsp_level   (e_level)
   );

   assign rsp_tuser = e_status;
   assign rsp_tdata = RspDataWidth'({e_level, e_handle});

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Randomized stream test of the three-level priority queue scheduler. A
// scoreboard class tracks the three handle queues, the high grant run and the
// stop state, and predicts one response per request. Requests cover full and
// empty queues, burst limits from 0 to 255, the high-only overflow case, the
// unused mode and stop. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
   import tpqs_pkg::*;

   localparam int ReqBits     = 24;   // priority_req, job_handle, pad
   localparam int RspBits     = 24;   // granted_handle, granted_priority, pad
   localparam int QueueSlots  = 16;
   localparam int ReportLimit = 10;
   localparam int StallLimit  = 2000;

   typedef struct {
      status_type      status;
      logic [15:0]     handle;
      logic [1:0]      level;
   } grant_type;

   class sched_scoreboard;
      logic [15:0]      level_q[NumLevels][$];
      logic [7:0]       burst_limit;
      logic [7:0]       high_run;
      bit               halted;
      grant_type        grant_q[$];
      int               errors;

      function new();
         burst_limit = BurstLimitReset;
         high_run    = '0;
         halted      = 1'b0;
         errors      = 0;
      endfunction

      function void set_limit(logic [7:0] value);
         burst_limit = value;
      endfunction

      function int pending();
         return grant_q.size();
      endfunction

      function void take(int lvl, ref grant_type g);
         g.handle = level_q[lvl].pop_front();
         g.level  = lvl[1:0];
      endfunction

      function void note_request(op_type op, logic [1:0] lvl, logic [15:0] handle);
         grant_type g;
         int        target;
         g.status = ST_OK;
         g.handle = '0;
         g.level  = '0;
         target   = (lvl > LVL_HIGH) ? int'(LVL_HIGH) : int'(lvl);
         case (op)
            OP_ENQ: begin
               if (halted)
                  g.status = ST_STOPPED;
               else if (level_q[target].size() >= QueueSlots)
                  g.status = ST_FULL;
               else
                  level_q[target].push_back(handle);
            end
            OP_DEQ: begin
               if (halted) begin
                  g.status = ST_STOPPED;
               end else if (level_q[LVL_HIGH].size() != 0 && high_run < burst_limit) begin
                  take(LVL_HIGH, g);
                  high_run++;
               end else if (level_q[LVL_NORMAL].size() != 0) begin
                  take(LVL_NORMAL, g);
                  high_run = '0;
               end else if (level_q[LVL_LOW].size() != 0) begin
                  take(LVL_LOW, g);
                  high_run = '0;
               end else if (level_q[LVL_HIGH].size() != 0) begin
                  take(LVL_HIGH, g);
               end else begin
                  g.status = ST_EMPTY;
               end
            end
            OP_STOP: halted = 1'b1;
            default: ;
         endcase
         grant_q.push_back(g);
      endfunction

      function void check_grant(logic [1:0] status, logic [15:0] handle, logic [1:0] level);
         grant_type g;
         if (grant_q.size() == 0) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: unexpected response status=%0d handle=%h level=%0d",
                        $realtime, status, handle, level);
            return;
         end
         g = grant_q.pop_front();
         if (status !== g.status || handle !== g.handle || level !== g.level) begin
            errors++;
            if (errors <= ReportLimit)
               $display("%0t: mismatch exp status=%0d handle=%h level=%0d, got %0d %h %0d",
                        $realtime, g.status, g.handle, g.level, status, handle, level);
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               csr_wr_en   = 1'b0;
   logic [BurstWidth-1:0] csr_wr_data = '0;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [ModeWidth-1:0] req_tuser = '0;   // mode
   logic [ReqBits-1:0] req_tdata   = '0;   // priority_req, job_handle
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [StatusWidth-1:0] rsp_tuser;     // status
   logic [RspBits-1:0] rsp_tdata;         // granted_handle, granted_priority

   sched_scoreboard    board = new();
   bit                 quiet = 1'b0;
   int                 stall_left = 0;
   int                 idle_cycles = 0;

   three_level_priority_queue_scheduler_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   always #2 clock = ~clock;

   // response side: check and random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_grant(rsp_tuser, rsp_tdata[15:0], rsp_tdata[17:16]);
         if (quiet) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_word(op_type op, logic [1:0] lvl, logic [15:0] handle);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, handle, lvl};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, lvl, handle);
   endtask

   task automatic write_limit(logic [7:0] value);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_limit(value);
   endtask

   task automatic run_phase(int n_items);
      int         sent;
      int         kind;
      int         len;
      logic [1:0] burst_lvl;
      logic [1:0] lvl;
      op_type     op;
      sent = 0;
      while (sent < n_items) begin
         kind      = $urandom_range(0, 9);
         len       = $urandom_range(3, 20);
         burst_lvl = 2'($urandom_range(0, 3));
         for (int i = 0; i < len; i++) begin
            if (kind < 4)
               op = ($urandom_range(0, 4) != 0) ? OP_ENQ : OP_DEQ;
            else if (kind < 8)
               op = ($urandom_range(0, 4) != 0) ? OP_DEQ : OP_ENQ;
            else
               op = ($urandom_range(0, 1) != 0) ? OP_ENQ : OP_DEQ;
            if ($urandom_range(0, 39) == 0)
               op = OP_NONE;
            lvl = ($urandom_range(0, 2) != 0) ? burst_lvl : 2'($urandom_range(0, 3));
            send_word(op, lvl, 16'($urandom));
            if (op != OP_NONE)
               sent++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default limit of 4
      send_word(OP_DEQ, LVL_LOW, 16'h0000);
      send_word(OP_ENQ, LVL_HIGH, 16'h0000);
      send_word(OP_ENQ, LVL_HIGH, 16'hFFFF);
      send_word(OP_ENQ, 2'd3, 16'hAAAA);
      send_word(OP_ENQ, 2'd3, 16'h5555);
      send_word(OP_ENQ, LVL_HIGH, 16'h1234);
      send_word(OP_ENQ, LVL_HIGH, 16'h8001);
      send_word(OP_ENQ, LVL_NORMAL, 16'hFFFF);
      send_word(OP_ENQ, LVL_LOW, 16'h0000);
      send_word(OP_NONE, 2'd3, 16'hFFFF);
      repeat (9) send_word(OP_DEQ, 2'd3, 16'hFFFF);

      // zero limit: high-only work still served, normal preferred
      write_limit(8'd0);
      send_word(OP_ENQ, LVL_HIGH, 16'hC3C3);
      send_word(OP_ENQ, LVL_NORMAL, 16'h3C3C);
      send_word(OP_DEQ, LVL_LOW, 16'h0000);
      send_word(OP_DEQ, LVL_LOW, 16'h0000);
      send_word(OP_DEQ, LVL_LOW, 16'h0000);

      run_phase(180);
      write_limit(8'd255);
      run_phase(180);
      write_limit(8'd1);
      run_phase(180);
      write_limit(8'd0);
      run_phase(150);
      write_limit(8'($urandom_range(2, 254)));
      run_phase(180);
      write_limit(8'd3);
      run_phase(180);
      write_limit(8'd4);
      quiet = 1'b1;
      run_phase(180);

      // stop, then every enqueue and dequeue is refused
      send_word(OP_ENQ, LVL_NORMAL, 16'h7E7E);
      send_word(OP_STOP, LVL_LOW, 16'h0000);
      send_word(OP_ENQ, LVL_HIGH, 16'hFFFF);
      send_word(OP_DEQ, LVL_LOW, 16'h0000);
      send_word(OP_STOP, 2'd3, 16'hFFFF);
      send_word(OP_NONE, LVL_LOW, 16'h0000);
      send_word(OP_DEQ, LVL_HIGH, 16'h0000);

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
